// ----- hw/rtl/kbd_pkg.sv -----
// ----------------------------------------------------------------------------
// kbd_pkg
// Shared codes and payload types for the keyboard buffer device.
// ----------------------------------------------------------------------------
package kbd_pkg;

    // Item kinds carried in the opcode field
    localparam logic [1:0] OP_CMD     = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // CPU interrupt commands in register A
    localparam logic [15:0] CMD_CLEAR   = 16'd0;
    localparam logic [15:0] CMD_GET_KEY = 16'd1;
    localparam logic [15:0] CMD_QUERY   = 16'd2;
    localparam logic [15:0] CMD_SET_MSG = 16'd3;

    // Highest key code
    localparam logic [15:0] KEY_MAX = 16'h00FF;

    // Key code width and number of key codes
    localparam int KEY_W    = 8;
    localparam int NUM_KEYS = 256;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [15:0]      cmd_a;
        logic [15:0]      arg_b;
        logic [KEY_W-1:0] key_code;
    } t_in_item;

    typedef struct packed {
        logic        c_write;
        logic [15:0] c_value;
        logic        irq_raise;
        logic [15:0] irq_message;
        logic        bad_command;
    } t_out_item;

endpackage

// ----- hw/rtl/kbd_if.sv -----
// ----------------------------------------------------------------------------
// kbd_if
// Valid/ready channels of the keyboard buffer device: events in, results out.
// ----------------------------------------------------------------------------
interface kbd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] cmd_a;
    logic [15:0] arg_b;
    logic [7:0]  key_code;

    modport source (output valid, output opcode, output cmd_a, output arg_b,
                    output key_code, input ready);
    modport sink   (input valid, input opcode, input cmd_a, input arg_b,
                    input key_code, output ready);
endinterface

interface kbd_out_if;
    logic        valid;
    logic        ready;
    logic        c_write;
    logic [15:0] c_value;
    logic        irq_raise;
    logic [15:0] irq_message;
    logic        bad_command;

    modport source (output valid, output c_write, output c_value, output irq_raise,
                    output irq_message, output bad_command, input ready);
    modport sink   (input valid, input c_write, input c_value, input irq_raise,
                    input irq_message, input bad_command, output ready);
endinterface

// ----- hw/rtl/kbd_ram.sv -----
// ----------------------------------------------------------------------------
// kbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port (old data on a same-address write)
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/keyboard_buffer_device_top.sv -----
// An item passes the input register, then the result register, and its result
// transfers when the output is ready; a stalled result also stalls the input.
// Throughput: one item per cycle while the result is not stalled, set by the
// single read-modify-write of the key ring, pressed map and message per item.
// Reset (synchronous, active low) empties the ring and clears the message; the
// pressed map is then cleared one key per cycle, and input waits until done.
// ----------------------------------------------------------------------------
// keyboard_buffer_device_top
// Keyboard device: ring of typed keys, pressed-key map, interrupt message,
// driven by key events and CPU interrupt commands.
// ----------------------------------------------------------------------------
module keyboard_buffer_device_top #(
    parameter int FIFO_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    kbd_in_if.sink           i_in,
    kbd_out_if.source        o_out
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Input stage
    logic                  r_in_valid;
    kbd_pkg::t_in_item     r_in;
    logic                  in_take;
    logic                  fire;

    // State
    logic [CNT_W-1:0]      r_count,  n_count;
    logic [PTR_W-1:0]      r_head,   n_head;
    logic [15:0]           r_msg,    n_msg;

    // Pressed map update
    logic                  map_we;
    logic                  map_val;

    // Pressed map storage, forwarding and clearing pass
    logic                  key_down;
    logic                  map_rdata;
    logic [kbd_pkg::KEY_W-1:0] map_raddr;
    logic                  r_map_byp_valid;
    logic                  r_map_byp_data;
    logic                  r_clr_busy;
    logic [kbd_pkg::KEY_W-1:0] r_clr_addr;

    // Ring storage access
    logic                  ring_we;
    logic [PTR_W-1:0]      ring_waddr;
    logic [PTR_W-1:0]      ring_raddr;
    logic [kbd_pkg::KEY_W-1:0] ring_rdata;
    logic [kbd_pkg::KEY_W-1:0] head_key;
    logic                  r_byp_valid;
    logic [kbd_pkg::KEY_W-1:0] r_byp_data;
    logic [SUM_W-1:0]      tail_sum;
    logic [PTR_W-1:0]      head_inc;

    // Result stage
    logic                  r_out_valid;
    kbd_pkg::t_out_item    r_out, n_out;

    // Handshake; input closed while the pressed map is being cleared
    assign fire    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_clr_busy && (!r_in_valid || fire);
    assign in_take = i_in.valid && i_in.ready;

    // Ring addresses: tail = head + count modulo depth, next head wraps
    assign tail_sum   = SUM_W'(r_head) + SUM_W'(r_count);
    assign ring_waddr = (tail_sum >= SUM_W'(FIFO_DEPTH))
                        ? PTR_W'(tail_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc   = (r_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Oldest key: forwarded when it was written at the read edge
    assign head_key = r_byp_valid ? r_byp_data : ring_rdata;

    // Pressed bit: queried key for commands, event key otherwise
    assign map_raddr = (i_in.opcode == kbd_pkg::OP_CMD)
                       ? i_in.arg_b[kbd_pkg::KEY_W-1:0] : i_in.key_code;
    assign key_down  = r_map_byp_valid ? r_map_byp_data : map_rdata;

    // Item processing
    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_msg   = r_msg;
        map_we  = 1'b0;
        map_val = 1'b0;
        ring_we = 1'b0;
        n_out   = '0;
        case (r_in.opcode)
            kbd_pkg::OP_CMD: begin
                case (r_in.cmd_a)
                    kbd_pkg::CMD_CLEAR: begin
                        n_count = '0;
                        n_head  = '0;
                    end
                    kbd_pkg::CMD_GET_KEY: begin
                        n_out.c_write = 1'b1;
                        if (r_count != '0) begin
                            n_out.c_value = 16'(head_key);
                            n_head        = head_inc;
                            n_count       = r_count - 1'b1;
                        end
                    end
                    kbd_pkg::CMD_QUERY: begin
                        n_out.c_write = 1'b1;
                        if (r_in.arg_b <= kbd_pkg::KEY_MAX) begin
                            n_out.c_value = 16'(key_down);
                        end
                    end
                    kbd_pkg::CMD_SET_MSG: begin
                        n_msg = r_in.arg_b;
                    end
                    default: begin
                        n_out.bad_command = 1'b1;
                    end
                endcase
            end
            kbd_pkg::OP_PRESS: begin
                // Unknown key or key already down: no effect
                if (r_in.key_code != '0 && !key_down) begin
                    if (r_count != CNT_W'(FIFO_DEPTH)) begin
                        ring_we = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    map_we            = 1'b1;
                    map_val           = 1'b1;
                    n_out.irq_raise   = (r_msg != '0);
                    n_out.irq_message = r_msg;
                end
            end
            kbd_pkg::OP_RELEASE: begin
                if (r_in.key_code != '0) begin
                    map_we            = 1'b1;
                    map_val           = 1'b0;
                    n_out.irq_raise   = (r_msg != '0);
                    n_out.irq_message = r_msg;
                end
            end
            default: begin
                // unused opcode: empty result
            end
        endcase
    end

    // Read address for the next captured item: head after this cycle's update
    assign ring_raddr = fire ? n_head : r_head;

    kbd_ram #(
        .WIDTH (kbd_pkg::KEY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (fire && ring_we),
        .i_wr_addr (ring_waddr),
        .i_wr_data (r_in.key_code),
        .i_rd_en   (in_take),
        .i_rd_addr (ring_raddr),
        .o_rd_data (ring_rdata)
    );

    // Pressed map: clearing pass writes zeros, otherwise the event key
    kbd_ram #(
        .WIDTH (1),
        .DEPTH (kbd_pkg::NUM_KEYS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (r_clr_busy || (fire && map_we)),
        .i_wr_addr (r_clr_busy ? r_clr_addr : r_in.key_code),
        .i_wr_data (map_val && !r_clr_busy),
        .i_rd_en   (in_take),
        .i_rd_addr (map_raddr),
        .o_rd_data (map_rdata)
    );

    // Clearing pass after reset: one key per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.opcode   <= i_in.opcode;
            r_in.cmd_a    <= i_in.cmd_a;
            r_in.arg_b    <= i_in.arg_b;
            r_in.key_code <= i_in.key_code;
        end
    end

    // Write-to-read forwarding for the ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else if (in_take) begin
            r_byp_valid <= fire && ring_we && (ring_waddr == ring_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byp_data <= r_in.key_code;
        end
    end

    // Write-to-read forwarding for the pressed map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_byp_valid <= 1'b0;
        end else if (in_take) begin
            r_map_byp_valid <= fire && map_we && (r_in.key_code == map_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_map_byp_data <= map_val;
        end
    end

    // Device state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_head    <= '0;
            r_msg     <= '0;
        end else if (fire) begin
            r_count <= n_count;
            r_head  <= n_head;
            r_msg   <= n_msg;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.c_write     = r_out.c_write;
    assign o_out.c_value     = r_out.c_value;
    assign o_out.irq_raise   = r_out.irq_raise;
    assign o_out.irq_message = r_out.irq_message;
    assign o_out.bad_command = r_out.bad_command;

endmodule

// ----- hw/rtl/kbd_chk.sv -----
// ----------------------------------------------------------------------------
// kbd_chk
// Port-level checks of the keyboard buffer device, bound to the top level.
// ----------------------------------------------------------------------------
module kbd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_c_write,
    input logic [15:0] i_c_value,
    input logic        i_irq_raise,
    input logic [15:0] i_irq_message,
    input logic        i_bad_command
);

    // Coming out of reset: no result pending, input held while the map clears
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!i_out_valid && !i_in_ready))
        else $error("result pending or input open after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_c_write)
            && $stable(i_c_value) && $stable(i_irq_raise)
            && $stable(i_irq_message) && $stable(i_bad_command)))
        else $error("stalled result changed");

    // C value only with a C write, and then at most a key code
    a_c_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_c_write ? (i_c_value[15:8] == 8'h00) : (i_c_value == 16'h0000)))
        else $error("C value out of range");

    // Interrupt carries a nonzero message, none otherwise
    a_irq_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_irq_raise ? (i_irq_message != 16'h0000)
                                     : (i_irq_message == 16'h0000)))
        else $error("interrupt message mismatch");

    // Undefined commands have no other effect in the result
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_bad_command) |-> (!i_c_write && !i_irq_raise))
        else $error("bad command with C write or interrupt");

endmodule

bind keyboard_buffer_device_top kbd_chk u_kbd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_c_write     (o_out.c_write),
    .i_c_value     (o_out.c_value),
    .i_irq_raise   (o_out.irq_raise),
    .i_irq_message (o_out.irq_message),
    .i_bad_command (o_out.bad_command)
);

// ----- verif/kbd_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// kbd_tb_pkg
// Result prediction and checking for the keyboard buffer device bench: keeps
// its own key ring, pressed-key map and interrupt message, and compares every
// result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
package kbd_tb_pkg;

    import kbd_pkg::*;

    // Opcode with no defined meaning, and the key code for an unknown key
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [7:0] KEY_UNKNOWN = 8'd0;

    // Mismatches shown in full; later ones are only counted
    localparam int SHOW_LIMIT = 10;

    class kbd_event_scoreboard #(int DEPTH = 16);

        logic [7:0]  key_ring [DEPTH];
        int unsigned ring_count;
        int unsigned ring_head;
        bit          key_down [NUM_KEYS];
        logic [15:0] irq_msg;
        t_out_item   expected_q [$];
        int          errors;

        function new();
            ring_count = 0;
            ring_head  = 0;
            irq_msg    = '0;
            errors     = 0;
            foreach (key_down[k]) key_down[k] = 1'b0;
            foreach (key_ring[k]) key_ring[k] = '0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("%0t: %s", $time, msg);
        endfunction

        function string show(t_out_item r);
            return $sformatf("c_write=%0d c_value=%h irq_raise=%0d irq_message=%h bad_command=%0d",
                             r.c_write, r.c_value, r.irq_raise, r.irq_message,
                             r.bad_command);
        endfunction

        // Update the device state for one accepted event and queue its result
        function void take_event(t_in_item it);
            t_out_item res;
            bit        raise;
            res   = '0;
            raise = 1'b0;
            case (it.opcode)
                OP_CMD: begin
                    case (it.cmd_a)
                        CMD_CLEAR: begin
                            ring_count = 0;
                            ring_head  = 0;
                        end
                        CMD_GET_KEY: begin
                            res.c_write = 1'b1;
                            if (ring_count > 0) begin
                                res.c_value = {8'h00, key_ring[ring_head]};
                                ring_head   = (ring_head + 1) % DEPTH;
                                ring_count--;
                            end
                        end
                        CMD_QUERY: begin
                            res.c_write = 1'b1;
                            if (it.arg_b <= KEY_MAX)
                                res.c_value = {15'd0, key_down[it.arg_b[7:0]]};
                        end
                        CMD_SET_MSG: irq_msg = it.arg_b;
                        default:     res.bad_command = 1'b1;
                    endcase
                end
                OP_PRESS: begin
                    // new key: enqueue if there is room, mark it down either way
                    if (it.key_code != KEY_UNKNOWN && !key_down[it.key_code]) begin
                        if (ring_count < DEPTH) begin
                            key_ring[(ring_head + ring_count) % DEPTH] = it.key_code;
                            ring_count++;
                        end
                        key_down[it.key_code] = 1'b1;
                        raise = 1'b1;
                    end
                end
                OP_RELEASE: begin
                    if (it.key_code != KEY_UNKNOWN) begin
                        key_down[it.key_code] = 1'b0;
                        raise = 1'b1;
                    end
                end
                default: ;
            endcase
            // a zero message means interrupts are off
            if (raise && irq_msg != '0) begin
                res.irq_raise   = 1'b1;
                res.irq_message = irq_msg;
            end
            expected_q.push_back(res);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report({"result with nothing pending: ", show(got)});
                return;
            end
            want = expected_q.pop_front();
            if (got.c_write !== want.c_write || got.c_value !== want.c_value ||
                got.irq_raise !== want.irq_raise || got.irq_message !== want.irq_message ||
                got.bad_command !== want.bad_command)
                report({"mismatch: expected ", show(want), " got ", show(got)});
        endfunction

    endclass

endpackage

// ----- verif/keyboard_buffer_device_top_tb.sv -----
// ----------------------------------------------------------------------------
// keyboard_buffer_device_top_tb
// Drives key press/release events and CPU commands into the keyboard device
// with random gaps on both channels: a directed sequence over the corner
// cases, then phased random traffic that fills, drains and mixes the key
// ring. Every result transfer is checked against the scoreboard prediction.
// ----------------------------------------------------------------------------
module keyboard_buffer_device_top_tb;

    import kbd_pkg::*;
    import kbd_tb_pkg::*;

    localparam int RING_DEPTH  = 16;
    localparam int RAND_EVENTS = 800;

    logic i_clk;
    logic i_rst_n;

    kbd_in_if  ev_if ();
    kbd_out_if res_if ();

    kbd_event_scoreboard #(RING_DEPTH) results;

    int calm_tx;
    int calm_rx;

    keyboard_buffer_device_top #(
        .FIFO_DEPTH (RING_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_if),
        .o_out   (res_if)
    );

    // Clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop
    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Wait before a transfer: a random gap, with occasional stretches of none
    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(10, 40);
        return $urandom_range(0, 13);
    endfunction

    // Mostly a small set of keys so presses and releases meet held keys
    function automatic logic [7:0] pick_key();
        if ($urandom_range(0, 9) < 6)
            return 8'($urandom_range(1, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_in_item mk_event(logic [1:0] op, logic [15:0] a,
                                          logic [15:0] b, logic [7:0] key);
        t_in_item it;
        it.opcode   = op;
        it.cmd_a    = a;
        it.arg_b    = b;
        it.key_code = key;
        return it;
    endfunction

    // One input transfer; entered and left at a falling edge
    task automatic send_event(t_in_item it);
        int gap;
        gap = pick_wait(calm_tx);
        if (gap > 0) begin
            ev_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        ev_if.opcode   = it.opcode;
        ev_if.cmd_a    = it.cmd_a;
        ev_if.arg_b    = it.arg_b;
        ev_if.key_code = it.key_code;
        ev_if.valid    = 1'b1;
        do @(posedge i_clk); while (!ev_if.ready);
        results.take_event(it);
        @(negedge i_clk);
    endtask

    // Result side: random stalls, check every transfer
    initial begin
        t_out_item got;
        int        stall;
        res_if.ready = 1'b0;
        calm_rx      = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = pick_wait(calm_rx);
            if (stall > 0) begin
                res_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            got.c_write     = res_if.c_write;
            got.c_value     = res_if.c_value;
            got.irq_raise   = res_if.irq_raise;
            got.irq_message = res_if.irq_message;
            got.bad_command = res_if.bad_command;
            results.check_result(got);
            @(negedge i_clk);
        end
    end

    // Stimulus
    initial begin
        t_in_item it;
        int       mode;
        int       pick;
        int       drain_wait;
        results        = new();
        calm_tx        = 0;
        ev_if.valid    = 1'b0;
        ev_if.opcode   = '0;
        ev_if.cmd_a    = '0;
        ev_if.arg_b    = '0;
        ev_if.key_code = '0;
        i_rst_n        = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: unknown key, messages off, held key, stray release, queries,
        // empty and cleared ring, undefined commands, unused opcode
        send_event(mk_event(OP_PRESS,   16'hFFFF, 16'hFFFF, KEY_UNKNOWN));
        send_event(mk_event(OP_PRESS,   16'h0000, 16'h0000, 8'hFF));
        send_event(mk_event(OP_CMD,     CMD_SET_MSG, 16'hFFFF, 8'h00));
        send_event(mk_event(OP_PRESS,   16'h0000, 16'h0000, 8'h01));
        send_event(mk_event(OP_PRESS,   16'h0000, 16'h0000, 8'h01));
        send_event(mk_event(OP_RELEASE, 16'h0000, 16'h0000, 8'h80));
        send_event(mk_event(OP_RELEASE, 16'hFFFF, 16'hFFFF, KEY_UNKNOWN));
        send_event(mk_event(OP_CMD,     CMD_QUERY, KEY_MAX, 8'hFF));
        send_event(mk_event(OP_CMD,     CMD_QUERY, 16'h0100, 8'h00));
        send_event(mk_event(OP_CMD,     CMD_QUERY, 16'hFFFF, 8'h00));
        send_event(mk_event(OP_CMD,     CMD_QUERY, 16'h0000, 8'h00));
        send_event(mk_event(OP_CMD,     CMD_GET_KEY, 16'h0000, 8'h00));
        send_event(mk_event(OP_CMD,     CMD_GET_KEY, 16'hFFFF, 8'hFF));
        send_event(mk_event(OP_CMD,     CMD_GET_KEY, 16'h0000, 8'h00));
        send_event(mk_event(OP_PRESS,   16'hFFFF, 16'hFFFF, 8'h55));
        send_event(mk_event(OP_CMD,     CMD_CLEAR, 16'h0000, 8'h00));
        send_event(mk_event(OP_CMD,     CMD_GET_KEY, 16'h0000, 8'h00));
        send_event(mk_event(OP_CMD,     16'd4, 16'h0000, 8'h00));
        send_event(mk_event(OP_CMD,     16'hFFFF, 16'hFFFF, 8'hFF));
        send_event(mk_event(OP_UNUSED,  16'hFFFF, 16'hFFFF, 8'hFF));
        send_event(mk_event(OP_RELEASE, 16'h0000, 16'h0000, 8'hFF));
        send_event(mk_event(OP_CMD,     CMD_SET_MSG, 16'h0001, 8'h00));
        send_event(mk_event(OP_PRESS,   16'h0000, 16'h0000, 8'hAA));
        send_event(mk_event(OP_CMD,     CMD_SET_MSG, 16'h0000, 8'h00));
        send_event(mk_event(OP_RELEASE, 16'h0000, 16'h0000, 8'h01));

        // Random: phases that fill the ring, drain it, or mix everything
        mode = 2;
        for (int n = 0; n < RAND_EVENTS; n++) begin
            if (n % 40 == 0)
                mode = $urandom_range(0, 2);
            it.opcode   = 2'($urandom_range(0, 3));
            it.cmd_a    = 16'($urandom());
            it.arg_b    = 16'($urandom());
            it.key_code = pick_key();
            pick        = $urandom_range(0, 99);
            if (mode == 0) begin
                pick = (pick < 70) ? 0 : (pick < 80) ? 1 : (pick < 90) ? 4 : 2;
            end else if (mode == 1) begin
                pick = (pick < 50) ? 2 : (pick < 75) ? 1 : (pick < 85) ? 3 :
                       (pick < 90) ? 6 : 0;
            end else begin
                pick = (pick < 25) ? 0 : (pick < 45) ? 1 : (pick < 60) ? 2 :
                       (pick < 75) ? 3 : (pick < 83) ? 4 : (pick < 93) ? 5 :
                       (pick < 96) ? 6 : 7;
            end
            case (pick)
                0: it.opcode = OP_PRESS;
                1: it.opcode = OP_RELEASE;
                2: begin
                    it.opcode = OP_CMD;
                    it.cmd_a  = CMD_GET_KEY;
                end
                3: begin
                    it.opcode = OP_CMD;
                    it.cmd_a  = CMD_QUERY;
                    if ($urandom_range(0, 9) < 7)
                        it.arg_b = {8'h00, pick_key()};
                end
                4: begin
                    it.opcode = OP_CMD;
                    it.cmd_a  = CMD_SET_MSG;
                    if ($urandom_range(0, 4) == 0)
                        it.arg_b = '0;
                end
                5: begin
                    it.opcode = OP_CMD;
                    it.cmd_a  = 16'($urandom_range(4, 65535));
                end
                6: begin
                    it.opcode = OP_CMD;
                    it.cmd_a  = CMD_CLEAR;
                end
                default: it.opcode = OP_UNUSED;
            endcase
            send_event(it);
        end
        ev_if.valid = 1'b0;

        // Drain, then wait on for anything stray
        while (results.expected_q.size() != 0) @(posedge i_clk);
        drain_wait = 8;
        repeat (drain_wait) @(posedge i_clk);
        if (results.expected_q.size() != 0)
            results.report($sformatf("%0d results never arrived", results.expected_q.size()));

        if (results.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/kbd_pkg.sv
hw/rtl/kbd_if.sv
hw/rtl/kbd_ram.sv
hw/rtl/keyboard_buffer_device_top.sv
hw/rtl/kbd_chk.sv
verif/kbd_tb_pkg.sv
verif/keyboard_buffer_device_top_tb.sv
